// ===== src/lsc_pkg.sv =====
package lsc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 15;
    localparam int NUM_CH      = 4;
    localparam int DARK_W      = FRAC_BITS + 1;
    localparam int LEVELS_W    = NUM_CH * SAMPLE_BITS;
    localparam int CFG_W       = LEVELS_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WHITE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINSIG = 2'd2;

    localparam logic [DARK_W-1:0] DARK_ONE = DARK_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_0;
        logic [SAMPLE_BITS-1:0] sample_1;
        logic [SAMPLE_BITS-1:0] sample_2;
        logic [SAMPLE_BITS-1:0] sample_3;
    } t_in;

    typedef struct packed {
        logic [DARK_W-1:0]        dark_0;
        logic [DARK_W-1:0]        dark_1;
        logic [DARK_W-1:0]        dark_2;
        logic [DARK_W-1:0]        dark_3;
        logic [DARK_W-1:0]        signal_strength;
        logic signed [DARK_W-1:0] position_error;
        logic                     line_detected;
    } t_out;

endpackage

// ===== src/line_sensor_centroid.sv =====
// An input beat passes through 16 lane divide stages, 16 centroid divide stages
// and one output register before the result is valid at the output.
// Throughput: one item per cycle; the pipeline holds while the output is stalled.
// Four lanes each run a one-bit-per-stage restoring divider.
// Reset (synchronous, active low) clears valids, white levels to 0, black to all ones.
module line_sensor_centroid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lsc_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lsc_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [lsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lsc_pkg::CFG_W-1:0]     i_cfg_data
);
    import lsc_pkg::*;

    logic [LEVELS_W-1:0]    r_white, r_black;
    logic [DARK_W-1:0]      r_min;
    logic                   w_en;
    logic [NUM_CH-1:0]      w_lv;
    logic [DARK_W-1:0]      w_dark [NUM_CH];
    logic [SAMPLE_BITS-1:0] w_smp  [NUM_CH];
    logic                   w_mv;
    t_out                   w_res;
    logic                   r_ov;
    t_out                   r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white <= '0;
            r_black <= '1;
            r_min   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WHITE:  r_white <= i_cfg_data[LEVELS_W-1:0];
                CFG_BLACK:  r_black <= i_cfg_data[LEVELS_W-1:0];
                CFG_MINSIG: r_min   <= i_cfg_data[DARK_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_en       = !r_ov || !i_out_stall;
    assign o_in_stall = !w_en;

    assign w_smp[0] = i_in_data.sample_0;
    assign w_smp[1] = i_in_data.sample_1;
    assign w_smp[2] = i_in_data.sample_2;
    assign w_smp[3] = i_in_data.sample_3;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        lsc_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (i_in_valid),
            .i_sample (w_smp[c]),
            .i_white  (r_white[c*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_black  (r_black[c*SAMPLE_BITS +: SAMPLE_BITS]),
            .o_valid  (w_lv[c]),
            .o_dark   (w_dark[c])
        );
    end

    lsc_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (w_lv[0]),
        .i_dark       (w_dark),
        .i_min_signal (r_min),
        .o_valid      (w_mv),
        .o_res        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lv == '0) || (w_lv == '1))
        else $error("lanes out of step");

    a_dark_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.dark_0 <= DARK_ONE) && (o_out_data.dark_1 <= DARK_ONE)
            && (o_out_data.dark_2 <= DARK_ONE) && (o_out_data.dark_3 <= DARK_ONE))
        else $error("darkness above one");

    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.signal_strength == '0 && o_out_data.dark_0 == '0
            && o_out_data.dark_1 == '0 && o_out_data.dark_2 == '0
            && o_out_data.dark_3 == '0) |-> (o_out_data.position_error == '0))
        else $error("position without darkness");

    a_detect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && $stable(r_min)) |->
            (o_out_data.line_detected == (o_out_data.signal_strength >= r_min)))
        else $error("detect flag mismatch");
endmodule

// ===== src/lsc_div.sv =====
module lsc_div #(
    parameter int NW = 12,
    parameter int QW = 16,
    parameter int PW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);
    logic          r_v   [QW];
    logic [NW-1:0] r_rem [QW];
    logic [NW-1:0] r_den [QW];
    logic [QW-1:0] r_q   [QW];
    logic [PW-1:0] r_pay [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NW:0]   w_rin;
        logic [NW:0]   w_sub;
        logic [NW-1:0] w_den;
        logic [QW-1:0] w_qin;
        logic          w_bit;
        logic          w_vin;
        logic [PW-1:0] w_pin;

        if (k == 0) begin : g_first
            assign w_rin = {1'b0, i_num};
            assign w_den = i_den;
            assign w_qin = '0;
            assign w_vin = i_valid;
            assign w_pin = i_pay;
        end else begin : g_next
            assign w_rin = {r_rem[k-1], 1'b0};
            assign w_den = r_den[k-1];
            assign w_qin = r_q[k-1];
            assign w_vin = r_v[k-1];
            assign w_pin = r_pay[k-1];
        end

        assign w_sub = w_rin - {1'b0, w_den};
        assign w_bit = ~w_sub[NW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_bit ? w_sub[NW-1:0] : w_rin[NW-1:0];
                r_den[k] <= w_den;
                r_q[k]   <= {w_qin[QW-2:0], w_bit};
                r_pay[k] <= w_pin;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_q[QW-1];
    assign o_pay   = r_pay[QW-1];
endmodule

// ===== src/lsc_lane.sv =====
module lsc_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [lsc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [lsc_pkg::SAMPLE_BITS-1:0] i_white,
    input  logic [lsc_pkg::SAMPLE_BITS-1:0] i_black,
    output logic                        o_valid,
    output logic [lsc_pkg::DARK_W-1:0]  o_dark
);
    import lsc_pkg::*;

    logic [SAMPLE_BITS-1:0] w_lo, w_hi, w_span, w_off;
    logic                   w_zero, w_sat;
    logic [1:0]             w_flags;
    logic [DARK_W-1:0]      w_q;

    always_comb begin
        w_lo   = (i_black < i_white) ? i_black : i_white;
        w_hi   = (i_black < i_white) ? i_white : i_black;
        w_span = (w_hi == w_lo) ? SAMPLE_BITS'(1) : (w_hi - w_lo);
        w_zero = (i_sample <= w_lo);
        w_off  = w_zero ? '0 : (i_sample - w_lo);
        w_sat  = (w_off >= w_span);
    end

    lsc_div #(.NW(SAMPLE_BITS), .QW(DARK_W), .PW(2)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_num   (w_off),
        .i_den   (w_span),
        .i_pay   ({w_zero, w_sat}),
        .o_valid (o_valid),
        .o_quo   (w_q),
        .o_pay   (w_flags)
    );

    assign o_dark = w_flags[1] ? '0 : (w_flags[0] ? DARK_ONE : w_q);
endmodule

// ===== src/lsc_merge.sv =====
module lsc_merge (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [lsc_pkg::DARK_W-1:0] i_dark [lsc_pkg::NUM_CH],
    input  logic [lsc_pkg::DARK_W-1:0] i_min_signal,
    output logic                       o_valid,
    output lsc_pkg::t_out              o_res
);
    import lsc_pkg::*;

    localparam int TW = DARK_W + 2;
    localparam int MW = FRAC_BITS + 4;
    localparam int PW = 4 * DARK_W + DARK_W + 2;

    logic [TW-1:0]     w_total;
    logic [DARK_W-1:0] w_signal;
    logic signed [MW:0] w_num;
    logic [MW-1:0]     w_mag, w_den;
    logic              w_neg, w_zero;
    logic [PW-1:0]     w_pin, w_pout;
    logic [DARK_W-1:0] w_q;
    logic [DARK_W-1:0] p_d0, p_d1, p_d2, p_d3, p_sig;
    logic              p_neg, p_zero;

    always_comb begin
        w_total  = TW'(i_dark[0]) + TW'(i_dark[1]) + TW'(i_dark[2]) + TW'(i_dark[3]);
        w_signal = w_total[TW-1:2];
        w_num    = (MW+1)'(3 * ($signed({1'b0, MW'(i_dark[3])})
                                - $signed({1'b0, MW'(i_dark[0])}))
                 + ($signed({1'b0, MW'(i_dark[2])}) - $signed({1'b0, MW'(i_dark[1])})));
        w_neg    = w_num[MW];
        w_mag    = w_neg ? MW'(-w_num) : MW'(w_num);
        w_den    = MW'({w_total, 1'b0}) + MW'(w_total);
        w_zero   = (w_total == '0);
        w_pin    = {i_dark[0], i_dark[1], i_dark[2], i_dark[3], w_signal, w_neg, w_zero};
    end

    lsc_div #(.NW(MW), .QW(DARK_W), .PW(PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_num   (w_mag),
        .i_den   (w_den),
        .i_pay   (w_pin),
        .o_valid (o_valid),
        .o_quo   (w_q),
        .o_pay   (w_pout)
    );

    always_comb begin
        {p_d0, p_d1, p_d2, p_d3, p_sig, p_neg, p_zero} = w_pout;
        o_res.dark_0          = p_d0;
        o_res.dark_1          = p_d1;
        o_res.dark_2          = p_d2;
        o_res.dark_3          = p_d3;
        o_res.signal_strength = p_sig;
        o_res.line_detected   = (p_sig >= i_min_signal);
        if (p_zero) begin
            o_res.position_error = '0;
        end else if (p_neg) begin
            o_res.position_error = -$signed(w_q);
        end else if (w_q[FRAC_BITS]) begin
            o_res.position_error = $signed(DARK_ONE - DARK_W'(1));
        end else begin
            o_res.position_error = $signed(w_q);
        end
    end
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lsc_pkg::*;

    localparam int LATENCY = 34;
    localparam longint CYCLE_LIMIT = 400000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    line_sensor_centroid DUT (.*);

    logic [LEVELS_W-1:0] white_q;
    logic [LEVELS_W-1:0] black_q;
    logic [DARK_W-1:0]   min_signal_q;
    t_out                expected_q[$];
    int                  mismatches;
    int                  beats_out;
    int                  beats_in;
    longint              cycles;
    bit                  stall_pattern_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [DARK_W-1:0] channel_dark(logic [SAMPLE_BITS-1:0] v,
                                                      logic [SAMPLE_BITS-1:0] w,
                                                      logic [SAMPLE_BITS-1:0] b);
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic [31:0] span;
        logic [31:0] off;
        lo = (b < w) ? b : w;
        hi = (b < w) ? w : b;
        span = 32'(hi) - 32'(lo);
        if (span == 0) span = 1;
        if (v <= lo) return '0;
        off = 32'(v) - 32'(lo);
        if (off >= span) return DARK_ONE;
        return DARK_W'((off << FRAC_BITS) / span);
    endfunction

    function automatic t_out predict_centroid(t_in s);
        t_out r;
        logic [DARK_W-1:0] d[NUM_CH];
        logic [SAMPLE_BITS-1:0] smp[NUM_CH];
        longint total;
        longint num;
        longint mag;
        longint q;
        longint pos;
        smp[0] = s.sample_0; smp[1] = s.sample_1;
        smp[2] = s.sample_2; smp[3] = s.sample_3;
        total = 0;
        for (int i = 0; i < NUM_CH; i++) begin
            d[i] = channel_dark(smp[i], white_q[i*SAMPLE_BITS +: SAMPLE_BITS],
                                black_q[i*SAMPLE_BITS +: SAMPLE_BITS]);
            total += longint'(d[i]);
        end
        num = 3 * (longint'(d[3]) - longint'(d[0])) + (longint'(d[2]) - longint'(d[1]));
        pos = 0;
        if (total != 0) begin
            mag = (num < 0) ? -num : num;
            q = (mag << FRAC_BITS) / (3 * total);
            pos = (num < 0) ? -q : q;
            if (pos >= (1 << FRAC_BITS)) pos = (1 << FRAC_BITS) - 1;
            if (pos < -(1 << FRAC_BITS)) pos = -(1 << FRAC_BITS);
        end
        r.dark_0 = d[0]; r.dark_1 = d[1]; r.dark_2 = d[2]; r.dark_3 = d[3];
        r.signal_strength = DARK_W'(total / 4);
        r.position_error = DARK_W'(pos);
        r.line_detected = (DARK_W'(total / 4) >= min_signal_q);
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("Mismatch beat %0d %s: got %0h want %0h", beats_out, what, got, want);
    endtask

    // output stall pattern
    always @(negedge i_clk) begin
        if (!stall_pattern_on) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("Unexpected result beat %0d", beats_out);
            end else begin
                want = expected_q.pop_front();
                if (o_out_data.dark_0 !== want.dark_0)
                    report("dark_0", 32'(o_out_data.dark_0), 32'(want.dark_0));
                if (o_out_data.dark_1 !== want.dark_1)
                    report("dark_1", 32'(o_out_data.dark_1), 32'(want.dark_1));
                if (o_out_data.dark_2 !== want.dark_2)
                    report("dark_2", 32'(o_out_data.dark_2), 32'(want.dark_2));
                if (o_out_data.dark_3 !== want.dark_3)
                    report("dark_3", 32'(o_out_data.dark_3), 32'(want.dark_3));
                if (o_out_data.signal_strength !== want.signal_strength)
                    report("signal_strength", 32'(o_out_data.signal_strength),
                           32'(want.signal_strength));
                if (o_out_data.position_error !== want.position_error)
                    report("position_error", 32'(o_out_data.position_error),
                           32'(want.position_error));
                if (o_out_data.line_detected !== want.line_detected)
                    report("line_detected", 32'(o_out_data.line_detected),
                           32'(want.line_detected));
            end
            beats_out++;
        end
    end

    // leaves valid high; a gap or drain lowers it
    task automatic send_sample(t_in s);
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(predict_centroid(s));
        beats_in++;
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WHITE:  white_q = val[LEVELS_W-1:0];
            CFG_BLACK:  black_q = val[LEVELS_W-1:0];
            CFG_MINSIG: min_signal_q = val[DARK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic t_in make_sample(int a, int b, int c, int d);
        t_in s;
        s.sample_0 = SAMPLE_BITS'(a); s.sample_1 = SAMPLE_BITS'(b);
        s.sample_2 = SAMPLE_BITS'(c); s.sample_3 = SAMPLE_BITS'(d);
        return s;
    endfunction

    function automatic t_in rand_sample;
        return make_sample($urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic test_reset_levels;
        send_sample(make_sample(0, 0, 0, 0));
        send_sample(make_sample(4095, 4095, 4095, 4095));
        send_sample(make_sample(4095, 0, 0, 0));
        send_sample(make_sample(0, 0, 0, 4095));
        send_sample(make_sample(2048, 1024, 3000, 10));
        drain();
    endtask

    task automatic test_directed_levels;
        // ch0 normal, ch1 swapped, ch2 equal levels, ch3 narrow span
        write_reg(CFG_WHITE, {12'd100, 12'd500, 12'd3000, 12'd200});
        write_reg(CFG_BLACK, {12'd101, 12'd500, 12'd1000, 12'd3800});
        write_reg(CFG_MINSIG, CFG_W'(8192));
        send_sample(make_sample(0, 0, 0, 0));
        send_sample(make_sample(200, 1000, 500, 100));
        send_sample(make_sample(199, 999, 499, 99));
        send_sample(make_sample(201, 1001, 501, 101));
        send_sample(make_sample(3800, 3000, 501, 101));
        send_sample(make_sample(4095, 4095, 4095, 4095));
        send_sample(make_sample(4095, 0, 0, 0));
        send_sample(make_sample(0, 0, 0, 4095));
        send_sample(make_sample(0, 2000, 0, 0));
        send_sample(make_sample(0, 0, 4095, 0));
        send_sample(make_sample(2000, 2000, 501, 101));
        drain();
        write_reg(CFG_MINSIG, CFG_W'(32768));
        send_sample(make_sample(4095, 4095, 4095, 4095));
        send_sample(make_sample(4095, 4095, 4095, 0));
        drain();
        write_reg(CFG_MINSIG, CFG_W'(16'hFFFF));
        write_reg(CFG_WHITE, 48'hFFF_FFF_FFF_FFF);
        write_reg(CFG_BLACK, 48'h0);
        send_sample(make_sample(4095, 0, 2048, 1));
        send_sample(make_sample(2048, 4094, 1, 4095));
        drain();
        // unused register index must be ignored
        write_reg('1, '1);
        send_sample(make_sample(4095, 0, 2048, 1));
        drain();
    endtask

    task automatic random_phase(int items);
        int left;
        int burst;
        left = items;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > left) burst = left;
            for (int k = 0; k < burst; k++) send_sample(rand_sample());
            left -= burst;
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        drain();
    endtask

    task automatic test_random_settings;
        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_WHITE, CFG_W'({$urandom, $urandom}));
            write_reg(CFG_BLACK, CFG_W'({$urandom, $urandom}));
            write_reg(CFG_MINSIG, CFG_W'($urandom_range(0, 32768)));
            stall_pattern_on = (p != 1);
            random_phase(120);
        end
        stall_pattern_on = 1'b1;
    endtask

    task automatic test_calibrated_track;
        // realistic white/black, samples mostly inside span
        write_reg(CFG_WHITE, {12'd300, 12'd320, 12'd280, 12'd310});
        write_reg(CFG_BLACK, {12'd3600, 12'd3500, 12'd3700, 12'd3550});
        write_reg(CFG_MINSIG, CFG_W'(4000));
        random_phase(80);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        stall_pattern_on = 1'b1;
        white_q = '0;
        black_q = '1;
        min_signal_q = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_levels();
        test_directed_levels();
        test_random_settings();
        test_calibrated_track();
        $display("Sent %0d beats and checked %0d results over several calibrations,",
                 beats_in, beats_out);
        $display("including swapped, equal and extreme levels and thresholds.");
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
